[rtl/idxl_pkg.sv]
`timescale 1ns / 1ps

package idxl_pkg;

    localparam int KIND_W = 4;
    localparam int POS_W  = 5;
    localparam int CH_W   = 8;
    localparam int CNT_W  = 5;
    localparam int ST_W   = 2;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 4'd0,
        KIND_PUSH_FRONT = 4'd1,
        KIND_INSERT_AT  = 4'd2,
        KIND_REMOVE_AT  = 4'd3,
        KIND_POP_FRONT  = 4'd4,
        KIND_POP_BACK   = 4'd5,
        KIND_REPLACE_AT = 4'd6,
        KIND_READ_AT    = 4'd7,
        KIND_CLEAR      = 4'd8
    } kind_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_SHIFT_UP   = 2'd1,
        CELL_SHIFT_DOWN = 2'd2,
        CELL_WRITE      = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t        op;
        logic [CH_W-1:0] ch;
    } cell_ctrl_t;

endpackage

[rtl/idxl_cell.sv]
`timescale 1ns / 1ps

module idxl_cell
    import idxl_pkg::*;
#(
    parameter int IW = 4
) (
    input  logic            aclk,
    input  cell_ctrl_t      ctrl,
    input  logic [IW-1:0]   at,
    input  logic [IW-1:0]   idx,
    input  logic [CH_W-1:0] left,
    input  logic [CH_W-1:0] right,
    output logic [CH_W-1:0] q
);

    logic [CH_W-1:0] q_reg;
    logic [CH_W-1:0] q_next;

    always_comb begin
        q_next = q_reg;
        unique case (ctrl.op)
            CELL_HOLD: begin
                q_next = q_reg;
            end
            CELL_SHIFT_UP: begin
                if (idx > at) begin
                    q_next = left;
                end else if (idx == at) begin
                    q_next = ctrl.ch;
                end
            end
            CELL_SHIFT_DOWN: begin
                if (idx >= at) begin
                    q_next = right;
                end
            end
            CELL_WRITE: begin
                if (idx == at) begin
                    q_next = ctrl.ch;
                end
            end
            default: begin
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

[rtl/indexed_char_list.sv]
`timescale 1ns / 1ps

// Ordered byte list held in a row of DEPTH cells.
// Slave channel: one word per operation; s_tdata carries kind, position, ch.
// Master channel: one word per operation; m_tdata carries read_value,
// first_value, last_value, count and status after the operation.
// Every cell shifts up, shifts down, loads or holds in the cycle in which a
// word is accepted; one operation is taken per cycle while s_tready is high.
// Result path: the cells and the evaluation stage register the operation
// when it is accepted, then the output register selects the read, first and
// last bytes out of the row.
// Throughput: one word per cycle while m_tready stays high.
// Reset: length returns to zero and both stages empty; cell bytes keep their
// values but are never shown before they are rewritten.
// Stall: while m_tready is low the result holds in the output register, one
// more operation is taken into the evaluation stage, then s_tready drops.
module indexed_char_list
    import idxl_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // kind[3:0], position[8:4], ch[16:9], zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // read_value[7:0], first_value[15:8], last_value[23:16], count[28:24],
    // status[30:29], zero pad
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int IW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > POS_W) ? LW : POS_W;

    logic [KIND_W-1:0] in_kind;
    logic [POS_W-1:0]  in_pos;
    logic [CH_W-1:0]   in_ch;

    logic [LW-1:0] len_reg, len_next, len_dec;
    logic [CW-1:0] len_c, pos_c;
    logic          full, empty;

    cell_ctrl_t    cell_ctrl;
    cell_op_t      dec_op;
    logic [IW-1:0] cell_at, dec_at;
    status_t       dec_status;
    logic          dec_rd;
    logic [LW-1:0] len_m1;

    logic          eval_valid_reg;
    logic          eval_rd_reg;
    logic [IW-1:0] eval_idx_reg;
    status_t       eval_status_reg;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic accept, out_free;

    logic [CH_W-1:0] cells_q [DEPTH];
    logic [CH_W-1:0] left_w  [DEPTH];
    logic [CH_W-1:0] right_w [DEPTH];

    logic [CH_W-1:0] rd_val, first_val, last_val;
    logic [IW-1:0]   last_idx;
    logic [CW-1:0]   len_out_c;

    assign in_kind = s_tdata[KIND_W-1:0];
    assign in_pos  = s_tdata[KIND_W+POS_W-1:KIND_W];
    assign in_ch   = s_tdata[KIND_W+POS_W+CH_W-1:KIND_W+POS_W];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !eval_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    assign len_c  = CW'(len_reg);
    assign pos_c  = CW'(in_pos);
    assign full   = (len_reg == LW'(DEPTH));
    assign empty  = (len_reg == '0);
    assign len_m1 = len_reg - LW'(1);

    always_comb begin
        dec_op     = CELL_HOLD;
        dec_at     = '0;
        dec_status = ST_OK;
        dec_rd     = 1'b0;
        len_dec    = len_reg;
        unique case (kind_t'(in_kind))
            KIND_PUSH_BACK: begin
                if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_op  = CELL_SHIFT_UP;
                    dec_at  = len_reg[IW-1:0];
                    len_dec = len_reg + LW'(1);
                end
            end
            KIND_PUSH_FRONT: begin
                if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_op  = CELL_SHIFT_UP;
                    len_dec = len_reg + LW'(1);
                end
            end
            KIND_INSERT_AT: begin
                if (pos_c > len_c) begin
                    dec_status = ST_INDEX;
                end else if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_op  = CELL_SHIFT_UP;
                    dec_at  = pos_c[IW-1:0];
                    len_dec = len_reg + LW'(1);
                end
            end
            KIND_REMOVE_AT: begin
                if (pos_c >= len_c) begin
                    dec_status = ST_INDEX;
                end else begin
                    dec_op  = CELL_SHIFT_DOWN;
                    dec_at  = pos_c[IW-1:0];
                    len_dec = len_m1;
                end
            end
            KIND_POP_FRONT: begin
                if (empty) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_op  = CELL_SHIFT_DOWN;
                    len_dec = len_m1;
                end
            end
            KIND_POP_BACK: begin
                if (empty) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_op  = CELL_SHIFT_DOWN;
                    dec_at  = len_m1[IW-1:0];
                    len_dec = len_m1;
                end
            end
            KIND_REPLACE_AT: begin
                if (pos_c >= len_c) begin
                    dec_status = ST_INDEX;
                end else begin
                    dec_op = CELL_WRITE;
                    dec_at = pos_c[IW-1:0];
                end
            end
            KIND_READ_AT: begin
                if (pos_c >= len_c) begin
                    dec_status = ST_INDEX;
                end else begin
                    dec_rd = 1'b1;
                    dec_at = pos_c[IW-1:0];
                end
            end
            KIND_CLEAR: begin
                len_dec = '0;
            end
            default: begin
                dec_status = ST_OK;
            end
        endcase
    end

    assign cell_ctrl.op = accept ? dec_op : CELL_HOLD;
    assign cell_ctrl.ch = in_ch;
    assign cell_at      = dec_at;
    assign len_next     = accept ? len_dec : len_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign left_w[i] = '0;
        end else begin : g_mid_l
            assign left_w[i] = cells_q[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_w[i] = '0;
        end else begin : g_mid_r
            assign right_w[i] = cells_q[i+1];
        end

        idxl_cell #(
            .IW(IW)
        ) u_cell (
            .aclk  (aclk),
            .ctrl  (cell_ctrl),
            .at    (cell_at),
            .idx   (IW'(i)),
            .left  (left_w[i]),
            .right (right_w[i]),
            .q     (cells_q[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg        <= '0;
            eval_valid_reg <= 1'b0;
        end else begin
            len_reg <= len_next;
            if (accept) begin
                eval_valid_reg <= 1'b1;
            end else if (out_free) begin
                eval_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            eval_rd_reg     <= dec_rd;
            eval_idx_reg    <= dec_at;
            eval_status_reg <= dec_status;
        end
    end

    // select bytes out of the row as it stands after the operation
    assign last_idx  = len_m1[IW-1:0];
    assign first_val = empty ? '0 : cells_q[0];
    assign last_val  = empty ? '0 : cells_q[last_idx];
    assign rd_val    = eval_rd_reg ? cells_q[eval_idx_reg] : '0;
    assign len_out_c = CW'(len_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= eval_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && eval_valid_reg) begin
            m_tdata_reg <= {1'b0, eval_status_reg, len_out_c[CNT_W-1:0],
                            last_val, first_val, rd_val};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[rtl/idxl_checker.sv]
`timescale 1ns / 1ps

module idxl_checker
    import idxl_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    logic [CH_W-1:0]  chk_rd, chk_first, chk_last;
    logic [CNT_W-1:0] chk_count;
    logic [ST_W-1:0]  chk_status;

    assign chk_rd     = m_tdata[7:0];
    assign chk_first  = m_tdata[15:8];
    assign chk_last   = m_tdata[23:16];
    assign chk_count  = m_tdata[28:24];
    assign chk_status = m_tdata[30:29];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_fail_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chk_status != ST_OK |-> chk_rd == '0)
        else $error("read byte shown on a failed operation");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chk_status == ST_EMPTY |->
            chk_count == '0 && chk_first == '0 && chk_last == '0)
        else $error("empty status with a non-empty list");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (DEPTH >= 32) || (int'(chk_count) <= DEPTH))
        else $error("count beyond capacity");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chk_status == ST_FULL |->
            (DEPTH >= 32) || (int'(chk_count) == DEPTH))
        else $error("full status below capacity");

endmodule

bind indexed_char_list idxl_checker #(
    .DEPTH(DEPTH)
) u_idxl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
